// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. In a synthesis build SYNTH is set
// and every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked property with reset disable.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/ptb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg
// Sizes, register indexes and shared types of the page table builder.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int POOL_PAGES  = 16;
    localparam int IDX_W       = 9;
    localparam int ENTRIES     = 1 << IDX_W;
    localparam int PAGE_W      = $clog2(POOL_PAGES);
    localparam int CNT_W       = $clog2(POOL_PAGES + 1);
    localparam int ADDR_W      = PAGE_W + IDX_W;
    localparam int STORE_DEPTH = POOL_PAGES * ENTRIES;

    localparam int ENTRY_W     = 64;
    localparam int PPN_W       = 40;
    localparam int FLAG_W      = 12;
    localparam int VPN_W       = 36;
    localparam int PN_W        = ENTRY_W - FLAG_W;
    localparam int COUNT_W     = 5;
    localparam int CFG_DATA_W  = 40;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 1'd1;

    typedef struct packed {
        logic                re;
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [ENTRY_W-1:0]  wdata;
    } store_req_t;

    typedef struct packed {
        logic              present;
        logic              fault;
        logic [PAGE_W-1:0] page;
    } walk_decode_t;

endpackage

// ===== rtl/page_table_builder_bump_pool.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_builder_bump_pool
// Maps 4 KiB pages into a four-level table tree held in a bump-allocated pool.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; it
//   carries virt_page, phys_page and entry_flags. The result shows on
//   leaf_entry, tables_taken, pool_exhausted and pages_remaining for exactly
//   one cycle with done high; the receiver cannot stall it.
//   Each upper level that the walk reads costs one memory read and one decode
//   step, each missing level one write, and the leaf one write, all on the
//   single port of the table store. busy drops in the done cycle, so the next
//   request can be taken there.
//   A pool that cannot hold every missing table fails the request early
//   with pool_exhausted set and nothing written.
//   After reset the store is zeroed one entry a cycle, all STORE_DEPTH
//   entries (8192 with 16 pool pages), with busy high. Configuration writes
//   (cfg_we, cfg_index, cfg_data) are taken at any edge and are meant for
//   idle periods; index 0 is the pool base page, index 1 the page count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_table_builder_bump_pool
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ptb_pkg::VPN_W-1:0]         virt_page,
    input  logic [ptb_pkg::PPN_W-1:0]         phys_page,
    input  logic [ptb_pkg::FLAG_W-1:0]        entry_flags,
    input  logic                              cfg_we,
    input  logic [ptb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              done,
    output logic [ptb_pkg::ENTRY_W-1:0]       leaf_entry,
    output logic [1:0]                        tables_taken,
    output logic                              pool_exhausted,
    output logic [ptb_pkg::COUNT_W-1:0]       pages_remaining
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_ALLOC = 3'd4;
    localparam logic [2:0] S_LEAF  = 3'd5;

    localparam int CMP_W = ptb_pkg::CNT_W + ptb_pkg::COUNT_W;

    logic [2:0]                            state_reg, state_next;
    logic [1:0]                            level_reg, level_next;
    logic [ptb_pkg::PAGE_W-1:0]            page_reg, page_next;
    logic [3:0][ptb_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [ptb_pkg::PPN_W-1:0]             pp_reg, pp_next;
    logic [ptb_pkg::FLAG_W-1:0]            fl_reg, fl_next;
    logic [1:0]                            taken_reg, taken_next;
    logic [ptb_pkg::CNT_W-1:0]             nfi_reg, nfi_next;
    logic [ptb_pkg::CNT_W-1:0]             free_reg, free_next;
    logic [ptb_pkg::PPN_W-1:0]             base_reg, base_next;
    logic                                  done_reg, done_next;
    logic [ptb_pkg::ENTRY_W-1:0]           leaf_reg, leaf_next;
    logic [1:0]                            tt_reg, tt_next;
    logic                                  exh_reg, exh_next;
    logic [ptb_pkg::COUNT_W-1:0]           rem_reg, rem_next;

    ptb_pkg::store_req_t                   req;
    logic [ptb_pkg::ENTRY_W-1:0]           rdata;
    logic                                  clear_busy;
    ptb_pkg::walk_decode_t                 dec;

    logic [1:0]                            missing;
    logic [CMP_W-1:0]                      cnt_ext;
    logic [CMP_W-1:0]                      eff_cnt;
    logic [CMP_W-1:0]                      nfi_ext;
    logic [ptb_pkg::PPN_W-1:0]             new_addr;
    logic [ptb_pkg::ENTRY_W-1:0]           leaf_val;

    ptb_store u_store
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rdata      (rdata),
        .clear_busy (clear_busy)
    );

    ptb_entry_decode u_decode
    (
        .entry (rdata),
        .base  (base_reg),
        .dec   (dec)
    );

    assign missing  = 2'd3 - level_reg;
    assign new_addr = base_reg + ptb_pkg::PPN_W'(nfi_reg);
    assign leaf_val = {{(ptb_pkg::ENTRY_W - ptb_pkg::PPN_W - ptb_pkg::FLAG_W){1'b0}},
                       pp_reg, fl_reg};

    // Effective page count: zero counts as one, anything above the pool size
    // counts as the pool size.
    assign cnt_ext = CMP_W'(cfg_data[ptb_pkg::COUNT_W-1:0]);
    assign nfi_ext = CMP_W'(nfi_reg);
    always_comb
    begin
        if (cnt_ext == '0)
        begin
            eff_cnt = CMP_W'(1);
        end
        else if (cnt_ext > CMP_W'(ptb_pkg::POOL_PAGES))
        begin
            eff_cnt = CMP_W'(ptb_pkg::POOL_PAGES);
        end
        else
        begin
            eff_cnt = cnt_ext;
        end
    end

    always_comb
    begin
        req.re    = 1'b0;
        req.we    = 1'b0;
        req.addr  = {page_reg, idx_reg[level_reg]};
        req.wdata = leaf_val;
        case (state_reg)
            S_READ:
            begin
                req.re = 1'b1;
            end
            S_ALLOC:
            begin
                req.we    = 1'b1;
                req.wdata = {{(ptb_pkg::ENTRY_W - ptb_pkg::PPN_W - ptb_pkg::FLAG_W){1'b0}},
                             new_addr, fl_reg};
            end
            S_LEAF:
            begin
                req.we   = 1'b1;
                req.addr = {page_reg, idx_reg[3]};
            end
            default:
            begin
                req.re = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        page_next  = page_reg;
        idx_next   = idx_reg;
        pp_next    = pp_reg;
        fl_next    = fl_reg;
        taken_next = taken_reg;
        nfi_next   = nfi_reg;
        free_next  = free_reg;
        base_next  = base_reg;
        done_next  = 1'b0;
        leaf_next  = leaf_reg;
        tt_next    = tt_reg;
        exh_next   = exh_reg;
        rem_next   = rem_reg;

        case (state_reg)
            S_CLEAR:
            begin
                if (!clear_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next[0] = virt_page[35:27];
                    idx_next[1] = virt_page[26:18];
                    idx_next[2] = virt_page[17:9];
                    idx_next[3] = virt_page[8:0];
                    pp_next     = phys_page;
                    fl_next     = entry_flags | ptb_pkg::FLAG_W'(1);
                    level_next  = 2'd0;
                    page_next   = '0;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (dec.fault
                    || (!dec.present && (ptb_pkg::CNT_W'(missing) > free_reg)))
                begin
                    done_next  = 1'b1;
                    leaf_next  = '0;
                    tt_next    = 2'd0;
                    exh_next   = 1'b1;
                    rem_next   = ptb_pkg::COUNT_W'(free_reg);
                    state_next = S_IDLE;
                end
                else if (!dec.present)
                begin
                    taken_next = missing;
                    state_next = S_ALLOC;
                end
                else
                begin
                    page_next = dec.page;
                    if (level_reg == 2'd2)
                    begin
                        taken_next = 2'd0;
                        state_next = S_LEAF;
                    end
                    else
                    begin
                        level_next = level_reg + 2'd1;
                        state_next = S_READ;
                    end
                end
            end
            S_ALLOC:
            begin
                page_next  = nfi_reg[ptb_pkg::PAGE_W-1:0];
                nfi_next   = nfi_reg + 1'b1;
                free_next  = free_reg - 1'b1;
                level_next = level_reg + 2'd1;
                if (level_reg == 2'd2)
                begin
                    state_next = S_LEAF;
                end
            end
            S_LEAF:
            begin
                done_next  = 1'b1;
                leaf_next  = leaf_val;
                tt_next    = taken_reg;
                exh_next   = 1'b0;
                rem_next   = ptb_pkg::COUNT_W'(free_reg);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                ptb_pkg::CFG_POOL_BASE:
                begin
                    base_next = cfg_data[ptb_pkg::PPN_W-1:0];
                end
                ptb_pkg::CFG_POOL_COUNT:
                begin
                    free_next = (eff_cnt > nfi_ext) ? ptb_pkg::CNT_W'(eff_cnt - nfi_ext)
                                                    : '0;
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            level_reg <= 2'd0;
            page_reg  <= '0;
            taken_reg <= 2'd0;
            nfi_reg   <= ptb_pkg::CNT_W'(1);
            free_reg  <= ptb_pkg::CNT_W'(ptb_pkg::POOL_PAGES - 1);
            base_reg  <= '0;
            done_reg  <= 1'b0;
            leaf_reg  <= '0;
            tt_reg    <= 2'd0;
            exh_reg   <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            page_reg  <= page_next;
            taken_reg <= taken_next;
            nfi_reg   <= nfi_next;
            free_reg  <= free_next;
            base_reg  <= base_next;
            done_reg  <= done_next;
            leaf_reg  <= leaf_next;
            tt_reg    <= tt_next;
            exh_reg   <= exh_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        pp_reg  <= pp_next;
        fl_reg  <= fl_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign leaf_entry      = leaf_reg;
    assign tables_taken    = tt_reg;
    assign pool_exhausted  = exh_reg;
    assign pages_remaining = rem_reg;

    `ASSERT_CLK(a_done_when_idle, clk, rst_n, done |-> !busy, "result strobe while still busy")
    `ASSERT_NEVER(a_no_rw_overlap, clk, rst_n, req.re && req.we, "store read and write together")
    `ASSERT_CLK(a_alloc_in_pool, clk, rst_n, (state_reg == S_ALLOC) |-> (nfi_reg < ptb_pkg::CNT_W'(ptb_pkg::POOL_PAGES)), "allocation past the pool end")
    `ASSERT_CLK(a_pool_balance, clk, rst_n, ({1'b0, free_reg} + {1'b0, nfi_reg}) <= (ptb_pkg::CNT_W + 1)'(ptb_pkg::POOL_PAGES), "free and used pages exceed the pool")
    `ASSERT_CLK(a_busy_in_clear, clk, rst_n, clear_busy |-> busy, "request possible during clearing pass")

endmodule

// ===== rtl/ptb_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_store
// Table page store: one synchronous memory with registered read data and a
// zeroing sweep after reset.
// ----------------------------------------------------------------------------
module ptb_store
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ptb_pkg::store_req_t            req,
    output logic [ptb_pkg::ENTRY_W-1:0]    rdata,
    output logic                           clear_busy
);

    logic [ptb_pkg::ENTRY_W-1:0] mem [ptb_pkg::STORE_DEPTH];

    logic                        clr_busy_reg;
    logic                        clr_busy_next;
    logic [ptb_pkg::ADDR_W-1:0]  clr_addr_reg;
    logic [ptb_pkg::ADDR_W-1:0]  clr_addr_next;
    logic [ptb_pkg::ENTRY_W-1:0] rdata_reg;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ptb_pkg::ADDR_W'(ptb_pkg::STORE_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ===== rtl/ptb_entry_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_entry_decode
// Decodes a table entry read during the walk: present bit, pool range check
// and the pool page that the entry points to.
// ----------------------------------------------------------------------------
module ptb_entry_decode
(
    input  logic [ptb_pkg::ENTRY_W-1:0] entry,
    input  logic [ptb_pkg::PPN_W-1:0]   base,
    output ptb_pkg::walk_decode_t       dec
);

    logic [ptb_pkg::PN_W:0] diff;
    logic                   in_pool;

    // The top bit of the difference is the borrow: entry below the pool base.
    assign diff    = {1'b0, entry[ptb_pkg::ENTRY_W-1:ptb_pkg::FLAG_W]}
                   - (ptb_pkg::PN_W + 1)'(base);
    assign in_pool = !diff[ptb_pkg::PN_W]
                   && (diff[ptb_pkg::PN_W-1:0] < ptb_pkg::PN_W'(ptb_pkg::POOL_PAGES));

    assign dec.present = entry[0];
    assign dec.fault   = entry[0] && !in_pool;
    assign dec.page    = diff[ptb_pkg::PAGE_W-1:0];

endmodule

// ===== tb/sv/page_table_builder_bump_pool_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_builder_bump_pool_tb
// Self-checking bench for the four-level page table builder. A queue of map
// requests and register writes, built up front, feeds a clocked driver that
// inserts random idle bursts. An in-bench copy of the table pool and the bump
// allocator predicts each result. A clocked monitor checks every result, in
// order and field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module page_table_builder_bump_pool_tb;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int QUIET_TAIL     = 200;
    localparam int SETTLE_CYCLES  = 3;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_MAPS    = 1880;
    localparam int PHASE_LEN      = 310;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic { CMD_MAP, CMD_CFG } cmd_kind_t;

    typedef struct {
        cmd_kind_t                       kind;
        logic [ptb_pkg::VPN_W-1:0]       vp;
        logic [ptb_pkg::PPN_W-1:0]       pp;
        logic [ptb_pkg::FLAG_W-1:0]      flags;
        logic [ptb_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [ptb_pkg::CFG_DATA_W-1:0]  reg_val;
    } map_cmd_t;

    typedef struct packed {
        logic [ptb_pkg::ENTRY_W-1:0]  leaf;
        logic [1:0]                   taken;
        logic                         exhausted;
        logic [ptb_pkg::COUNT_W-1:0]  remaining;
    } map_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [ptb_pkg::VPN_W-1:0]        virt_page = '0;
    logic [ptb_pkg::PPN_W-1:0]        phys_page = '0;
    logic [ptb_pkg::FLAG_W-1:0]       entry_flags = '0;
    logic                             cfg_we = 1'b0;
    logic [ptb_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [ptb_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                             done;
    logic [ptb_pkg::ENTRY_W-1:0]      leaf_entry;
    logic [1:0]                       tables_taken;
    logic                             pool_exhausted;
    logic [ptb_pkg::COUNT_W-1:0]      pages_remaining;

    // Predicted pool contents and allocator state.
    logic [ptb_pkg::ENTRY_W-1:0]      pool_tables [0:ptb_pkg::STORE_DEPTH-1];
    logic [ptb_pkg::COUNT_W-1:0]      next_table;
    logic [ptb_pkg::COUNT_W-1:0]      free_tables;
    logic [ptb_pkg::PPN_W-1:0]        pool_base;
    logic [ptb_pkg::COUNT_W-1:0]      pool_count;

    map_cmd_t                         map_cmds [$];
    map_result_t                      leaf_results [$];
    logic [ptb_pkg::VPN_W-1:0]        known_vps [$];
    logic [ptb_pkg::PPN_W-1:0]        home_base;

    int idle_left    = 0;
    int quiet_run    = 0;
    int settle       = 0;
    int fail_count   = 0;
    int results_seen = 0;
    int total_maps   = 0;
    int stall_cycles = 0;

    page_table_builder_bump_pool DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .virt_page       (virt_page),
        .phys_page       (phys_page),
        .entry_flags     (entry_flags),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .leaf_entry      (leaf_entry),
        .tables_taken    (tables_taken),
        .pool_exhausted  (pool_exhausted),
        .pages_remaining (pages_remaining)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic logic [ptb_pkg::COUNT_W-1:0] usable_pages(
        input logic [ptb_pkg::COUNT_W-1:0] cnt);
        if (cnt == 0)
        begin
            return ptb_pkg::COUNT_W'(1);
        end
        if (cnt > ptb_pkg::POOL_PAGES)
        begin
            return ptb_pkg::COUNT_W'(ptb_pkg::POOL_PAGES);
        end
        return cnt;
    endfunction

    function automatic void write_register(input logic [ptb_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [ptb_pkg::CFG_DATA_W-1:0] val);
        logic [ptb_pkg::COUNT_W-1:0] usable;
        if (idx == ptb_pkg::CFG_POOL_BASE)
        begin
            pool_base = val[ptb_pkg::PPN_W-1:0];
        end
        else if (idx == ptb_pkg::CFG_POOL_COUNT)
        begin
            pool_count = val[ptb_pkg::COUNT_W-1:0];
            usable = usable_pages(pool_count);
            free_tables = (usable > next_table) ? usable - next_table : '0;
        end
    endfunction

    function automatic logic [ptb_pkg::ENTRY_W-1:0] table_address(
        input logic [ptb_pkg::COUNT_W-1:0] pg);
        logic [ptb_pkg::PPN_W-1:0] ppn;
        ppn = pool_base + {{(ptb_pkg::PPN_W-ptb_pkg::COUNT_W){1'b0}}, pg};
        return {{(ptb_pkg::ENTRY_W-ptb_pkg::PPN_W-12){1'b0}}, ppn, 12'd0};
    endfunction

    // Walks the present levels, then either fails the whole request or
    // allocates every missing table and writes the leaf.
    function automatic map_result_t predict_map(input logic [ptb_pkg::VPN_W-1:0] vp,
                                                input logic [ptb_pkg::PPN_W-1:0] pp,
                                                input logic [ptb_pkg::FLAG_W-1:0] flags);
        logic [ptb_pkg::IDX_W-1:0]   lvl_idx [4];
        logic [ptb_pkg::ENTRY_W-1:0] fl;
        logic [ptb_pkg::ENTRY_W-1:0] ent;
        logic [ptb_pkg::ENTRY_W-1:0] pn;
        logic [ptb_pkg::ENTRY_W-1:0] leaf;
        logic [ptb_pkg::PAGE_W-1:0]  page;
        logic                        fault;
        logic                        walking;
        int                          level;
        int                          missing;
        map_result_t                 res;
        fl = {{(ptb_pkg::ENTRY_W-ptb_pkg::FLAG_W){1'b0}}, flags} | 64'd1;
        lvl_idx[0] = vp[35:27];
        lvl_idx[1] = vp[26:18];
        lvl_idx[2] = vp[17:9];
        lvl_idx[3] = vp[8:0];
        page = '0;
        level = 0;
        fault = 1'b0;
        walking = 1'b1;
        while (walking && level < 3)
        begin
            ent = pool_tables[{page, lvl_idx[level]}];
            pn = ent >> 12;
            if (!ent[0])
            begin
                walking = 1'b0;
            end
            else if (pn < {24'd0, pool_base}
                     || (pn - {24'd0, pool_base}) >= ptb_pkg::POOL_PAGES)
            begin
                fault = 1'b1;
                walking = 1'b0;
            end
            else
            begin
                page = ptb_pkg::PAGE_W'(pn - {24'd0, pool_base});
                level++;
            end
        end
        missing = 3 - level;
        res.remaining = free_tables;
        if (fault || missing > free_tables)
        begin
            res.leaf = '0;
            res.taken = '0;
            res.exhausted = 1'b1;
            return res;
        end
        while (level < 3)
        begin
            pool_tables[{page, lvl_idx[level]}] = table_address(next_table) | fl;
            page = next_table[ptb_pkg::PAGE_W-1:0];
            next_table++;
            free_tables--;
            level++;
        end
        leaf = ({24'd0, pp} << 12) | fl;
        pool_tables[{page, lvl_idx[3]}] = leaf;
        res.leaf = leaf;
        res.taken = missing[1:0];
        res.exhausted = 1'b0;
        res.remaining = free_tables;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void add_map(input logic [ptb_pkg::VPN_W-1:0] vp,
                                    input logic [ptb_pkg::PPN_W-1:0] pp,
                                    input logic [ptb_pkg::FLAG_W-1:0] flags);
        map_cmd_t c;
        c.kind = CMD_MAP;
        c.vp = vp;
        c.pp = pp;
        c.flags = flags;
        c.reg_idx = '0;
        c.reg_val = '0;
        map_cmds.push_back(c);
        known_vps.push_back(vp);
        total_maps++;
    endfunction

    function automatic void add_cfg(input logic [ptb_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [ptb_pkg::CFG_DATA_W-1:0] val);
        map_cmd_t c;
        c.kind = CMD_CFG;
        c.vp = '0;
        c.pp = '0;
        c.flags = '0;
        c.reg_idx = idx;
        c.reg_val = val;
        map_cmds.push_back(c);
    endfunction

    // Most addresses share upper indices with pages already mapped, so the
    // walk gets past the root and lands in existing tables.
    function automatic logic [ptb_pkg::VPN_W-1:0] pick_vp();
        logic [ptb_pkg::VPN_W-1:0] seed_vp;
        logic [63:0]               rnd;
        seed_vp = known_vps[$urandom_range(0, known_vps.size() - 1)];
        rnd = rand64();
        case ($urandom_range(0, 19))
            0, 1, 2, 3:          return seed_vp;
            4, 5, 6, 7, 8, 9:    return {seed_vp[35:9], rnd[8:0]};
            10, 11, 12:          return {seed_vp[35:18], rnd[17:0]};
            13, 14:              return {seed_vp[35:27], rnd[26:0]};
            18:                  return '1;
            19:                  return '0;
            default:             return rnd[ptb_pkg::VPN_W-1:0];
        endcase
    endfunction

    function automatic logic [ptb_pkg::PPN_W-1:0] pick_pp();
        logic [63:0] rnd;
        rnd = rand64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return rnd[ptb_pkg::PPN_W-1:0];
        endcase
    endfunction

    function automatic logic [ptb_pkg::FLAG_W-1:0] pick_flags();
        logic [63:0] rnd;
        rnd = rand64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return rnd[ptb_pkg::FLAG_W-1:0];
        endcase
    endfunction

    always @(posedge clk)
    begin : driver
        logic     took;
        logic     nx_start;
        logic     nx_we;
        map_cmd_t cmd;
        if (rst_n)
        begin
            took = start && !busy;
            nx_start = start && !took;
            nx_we = 1'b0;
            if (cfg_we)
            begin
                write_register(cfg_index, cfg_data);
            end
            if (took)
            begin
                leaf_results.push_back(predict_map(virt_page, phys_page, entry_flags));
            end
            if (!nx_start)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (map_cmds.size() > 0)
                begin
                    cmd = map_cmds[0];
                    if (cmd.kind == CMD_MAP)
                    begin
                        void'(map_cmds.pop_front());
                        nx_start = 1'b1;
                        virt_page <= cmd.vp;
                        phys_page <= cmd.pp;
                        entry_flags <= cmd.flags;
                        if (quiet_run > 0)
                        begin
                            quiet_run--;
                        end
                        else if ($urandom_range(0, 39) == 0)
                        begin
                            quiet_run = $urandom_range(20, 80);
                        end
                        else if (map_cmds.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
                        begin
                            idle_left = $urandom_range(1, 18);
                        end
                    end
                    else
                    begin
                        // Registers change only once every request has
                        // returned and the block has gone quiet.
                        if (leaf_results.size() == 0 && !busy && !took && !cfg_we)
                        begin
                            settle++;
                        end
                        else
                        begin
                            settle = 0;
                        end
                        if (settle >= SETTLE_CYCLES)
                        begin
                            void'(map_cmds.pop_front());
                            nx_we = 1'b1;
                            cfg_index <= cmd.reg_idx;
                            cfg_data <= cmd.reg_val;
                            settle = 0;
                        end
                    end
                end
            end
            start <= nx_start;
            cfg_we <= nx_we;
        end
    end

    always @(posedge clk)
    begin : monitor
        map_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (leaf_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("result with no request pending: leaf %h taken %0d",
                             leaf_entry, tables_taken);
                    $display("  exh %0d rem %0d", pool_exhausted, pages_remaining);
                end
            end
            else
            begin
                want = leaf_results.pop_front();
                if (leaf_entry !== want.leaf || tables_taken !== want.taken ||
                    pool_exhausted !== want.exhausted || pages_remaining !== want.remaining)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("result %0d wrong: leaf %h/%h taken %0d/%0d",
                                 results_seen, want.leaf, leaf_entry, want.taken,
                                 tables_taken);
                        $display("  exh %0d/%0d rem %0d/%0d",
                                 want.exhausted, pool_exhausted, want.remaining,
                                 pages_remaining);
                    end
                end
            end
        end
    end

    // The limit covers the store clearing pass after reset.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("page_table_builder_bump_pool: mismatch");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [63:0] rnd;
        logic [ptb_pkg::CFG_DATA_W-1:0] count_val;
        int i;
        for (i = 0; i < ptb_pkg::STORE_DEPTH; i++)
        begin
            pool_tables[i] = '0;
        end
        pool_base = '0;
        pool_count = 5'd16;
        next_table = 5'd1;
        free_tables = usable_pages(pool_count) - 5'd1;
        rnd = rand64();
        home_base = {8'($urandom_range(1, 254)), rnd[31:0]};

        // Small pool: one full walk, a hit in the same leaf table, then two
        // requests that need more tables than are left.
        add_cfg(ptb_pkg::CFG_POOL_BASE, home_base);
        add_cfg(ptb_pkg::CFG_POOL_COUNT, 40'd4);
        add_map(36'h0, '0, '0);
        add_map(36'h1, '1, '1);
        add_map('1, pick_pp(), pick_flags());
        add_map(36'h200, pick_pp(), pick_flags());
        // A zero page count acts as one page.
        add_cfg(ptb_pkg::CFG_POOL_COUNT, 40'd0);
        add_map(36'h1FF, pick_pp(), pick_flags());
        add_map(36'h8000000, pick_pp(), pick_flags());
        // An oversized count is clamped to the pool size.
        add_cfg(ptb_pkg::CFG_POOL_COUNT, 40'd31);
        add_map(36'h200, pick_pp(), pick_flags());
        add_map(36'h40000, pick_pp(), pick_flags());
        add_map('1, pick_pp(), pick_flags());
        add_map('1, pick_pp(), pick_flags());
        add_map(36'h555555555, pick_pp(), pick_flags());
        // Moving the base makes the old tree decode outside the pool.
        add_cfg(ptb_pkg::CFG_POOL_BASE, '0);
        add_map(36'h0, pick_pp(), pick_flags());
        add_map(36'hAAAAAAAAA, pick_pp(), pick_flags());
        add_map(36'hAAAAAAAAA, pick_pp(), pick_flags());
        add_map(36'h123456789, pick_pp(), pick_flags());
        add_cfg(ptb_pkg::CFG_POOL_COUNT, 40'd16);
        add_cfg(ptb_pkg::CFG_POOL_BASE, '1);
        add_map(36'hAAAAAAAAA, pick_pp(), pick_flags());
        add_map(36'h0, pick_pp(), pick_flags());
        add_cfg(ptb_pkg::CFG_POOL_BASE, home_base);
        add_cfg(ptb_pkg::CFG_POOL_COUNT, 40'd1);
        add_map(36'h1, pick_pp(), pick_flags());

        for (i = 0; i < RANDOM_MAPS; i++)
        begin
            if (i % PHASE_LEN == 0 && i != 0)
            begin
                rnd = rand64();
                case ($urandom_range(0, 19))
                    0, 1, 2:  add_cfg(ptb_pkg::CFG_POOL_BASE, '0);
                    3:        add_cfg(ptb_pkg::CFG_POOL_BASE, '1);
                    4, 5:     add_cfg(ptb_pkg::CFG_POOL_BASE,
                                      rnd[ptb_pkg::CFG_DATA_W-1:0]);
                    default:  add_cfg(ptb_pkg::CFG_POOL_BASE, home_base);
                endcase
                rnd = rand64();
                count_val = rnd[ptb_pkg::CFG_DATA_W-1:0];
                count_val[ptb_pkg::COUNT_W-1:0] = 5'($urandom_range(0, 31));
                add_cfg(ptb_pkg::CFG_POOL_COUNT, count_val);
            end
            add_map(pick_vp(), pick_pp(), pick_flags());
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (results_seen < total_maps)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (leaf_results.size() != 0)
        begin
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("page_table_builder_bump_pool: match");
        end
        else
        begin
            $display("page_table_builder_bump_pool: mismatch");
        end
        $finish;
    end

endmodule
